[design/arcbz_pkg.sv]
// Package for the arc segment to cubic Bezier block.
// Fixed-point formats, pipeline record types and the CORDIC arctangent table.
// No dependencies.
package arcbz_pkg;

    localparam int UW  = 34;   // Q2.30 unit values, with headroom
    localparam int ZW  = 32;   // Q.29 angle residue
    localparam int PW  = 2 * UW;
    localparam int UO  = 36;   // rotated unit coordinate
    localparam int RPW = 68;   // radius times unit
    localparam int RVW = 38;   // scaled coordinate before centre add
    localparam int DW  = 32;   // divider denominator and remainder
    localparam int QW  = 33;   // divider quotient bits
    localparam int NW  = 62;   // divider numerator magnitude
    localparam int CORDIC_STEPS = 30;

    localparam longint ANG_PI2     = 843314857;
    localparam longint ANG_PI4     = 421657428;
    localparam longint SWEEP_MAX   = 421657428;
    localparam longint CORDIC_GAIN = 652032874;
    localparam longint ONE_Q30     = 1073741824;
    localparam longint RND30       = 536870912;
    localparam longint TY_LIM      = 64'sd2147483648;
    localparam longint RECIP3      = 64'sd2863311531;   // ceil(2^33 / 3)

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        rx;
        logic [30:0]        ry;
    } geom_t;

    typedef struct packed {
        logic signed [UW-1:0] x;
        logic signed [UW-1:0] y;
        logic signed [ZW-1:0] z;
    } cord_t;

    typedef struct packed {
        logic signed [UW-1:0] c;
        logic signed [UW-1:0] s;
        logic signed [UW-1:0] cm;
        logic signed [UW-1:0] sm;
    } trig_t;

    typedef struct packed {
        logic [QW-1:0] nlo;
        logic [DW-1:0] den;
        logic [DW-1:0] rem;
        logic [QW-1:0] quo;
        logic          neg;
        logic          ovf;
        logic          szero;
    } div_t;

    function automatic logic signed [ZW-1:0] atan_q29(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 32'sd421657428;
            1:  v = 32'sd248918915;
            2:  v = 32'sd131521918;
            3:  v = 32'sd66762579;
            4:  v = 32'sd33510843;
            5:  v = 32'sd16771758;
            6:  v = 32'sd8387925;
            7:  v = 32'sd4194219;
            8:  v = 32'sd2097141;
            9:  v = 32'sd1048575;
            10: v = 32'sd524288;
            11: v = 32'sd262144;
            12: v = 32'sd131072;
            13: v = 32'sd65536;
            14: v = 32'sd32768;
            15: v = 32'sd16384;
            16: v = 32'sd8192;
            17: v = 32'sd4096;
            18: v = 32'sd2048;
            19: v = 32'sd1024;
            20: v = 32'sd512;
            21: v = 32'sd256;
            22: v = 32'sd128;
            23: v = 32'sd64;
            24: v = 32'sd32;
            25: v = 32'sd16;
            26: v = 32'sd8;
            27: v = 32'sd4;
            28: v = 32'sd2;
            29: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic cord_t cord_step(input cord_t a, input int i);
        cord_t r;
        logic signed [UW-1:0] dx;
        logic signed [UW-1:0] dy;
        logic signed [ZW-1:0] at;
        dx = a.y >>> i;
        dy = a.x >>> i;
        at = atan_q29(i);
        if (!a.z[ZW-1])
        begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - at;
        end
        else
        begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + at;
        end
        return r;
    endfunction

endpackage

[design/arc_segment_to_cubic_bezier_top.sv]
// Arc segment to cubic Bezier control points, fully pipelined.
// Depends on arcbz_pkg (formats, record types, CORDIC table and step).
//
// Usage:
//   Raise start with one arc segment on the input ports; it is taken at
//   the clock edge where start is high and busy is low. busy stays low, so
//   a new segment may be transferred on every cycle.
//   Each result appears on p0_x..p3_y for exactly one cycle with done high,
//   in input order. Throughput is one segment per cycle. The pipeline is
//   built from two 30-step CORDIC pipelines run side by side, a 33-stage
//   one-bit-per-stage restoring divider for the handle offset, and the
//   multiply stages of the rotation and scaling.
//   The receiver cannot stall; done is a strobe and results are not held.
//   Reset clears all valid bits, so no result is produced for anything
//   in flight at reset. Data registers are not reset.
module arc_segment_to_cubic_bezier_top
    import arcbz_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic [30:0]        radius_x,
    input  logic [30:0]        radius_y,
    input  logic signed [31:0] arc_start,
    input  logic signed [29:0] arc_sweep,
    output logic               done,
    output logic signed [31:0] p0_x,
    output logic signed [31:0] p0_y,
    output logic signed [31:0] p1_x,
    output logic signed [31:0] p1_y,
    output logic signed [31:0] p2_x,
    output logic signed [31:0] p2_y,
    output logic signed [31:0] p3_x,
    output logic signed [31:0] p3_y
);

    localparam int S_IN  = 0;
    localparam int S_ANG = 1;
    localparam int S_Q   = 2;
    localparam int S_RED = 3;
    localparam int S_C0  = 4;
    localparam int S_CL  = S_C0 + CORDIC_STEPS - 1;
    localparam int S_T0  = S_CL + 1;
    localparam int S_T1  = S_T0 + 1;
    localparam int S_T2  = S_T1 + 1;
    localparam int S_T3  = S_T2 + 1;
    localparam int S_T4  = S_T3 + 1;
    localparam int S_D0  = S_T4 + 1;
    localparam int S_DL  = S_D0 + QW - 1;
    localparam int S_E0  = S_DL + 1;
    localparam int S_E1  = S_E0 + 1;
    localparam int S_F0  = S_E1 + 1;
    localparam int S_F1  = S_F0 + 1;
    localparam int S_G0  = S_F1 + 1;
    localparam int S_G1  = S_G0 + 1;
    localparam int S_G2  = S_G1 + 1;

    logic vld_reg [S_IN:S_G2];

    geom_t              geo_reg [S_IN:S_G1];
    logic signed [31:0] start_reg;
    logic signed [29:0] sweep_reg;

    logic signed [31:0] sw1_reg, sw1_next;
    logic signed [33:0] m1_reg, m1_next;
    logic signed [31:0] sw2_reg;
    logic signed [33:0] m2_reg;
    logic signed [3:0]  q2_reg, q2_next;
    logic signed [31:0] sw3_reg;
    logic signed [31:0] r3_reg, r3_next;
    logic               zf_reg [S_ANG:S_CL];
    logic [1:0]         qd_reg [S_RED:S_CL];

    cord_t ch_reg [0:CORDIC_STEPS-1];
    cord_t cq_reg [0:CORDIC_STEPS-1];

    trig_t                trig_reg [S_T0:S_E1];
    trig_t                trig_next;
    logic [31:0]          nmag_reg, nmag_next;
    logic                 nneg_reg, nneg_next;
    logic [63:0]          txp_reg;
    logic                 txn_reg;
    logic signed [UW-1:0] tx_reg, tx_next;
    logic signed [UW-1:0] ct_reg [S_T2:S_E1];
    logic signed [PW-1:0] tc_reg;
    div_t                 dv_reg [S_T4:S_DL];
    div_t                 dv0_next;
    div_t                 dv_next [S_D0:S_DL];
    logic signed [33:0]   qt_reg, qt_next;
    logic                 ez_reg;
    logic signed [UW-1:0] ty_reg, ty_next;

    logic signed [PW-1:0]  prod_reg [0:7];
    logic signed [PW-1:0]  prod_next [0:7];
    logic signed [UO-1:0]  unit_reg [0:7];
    logic signed [UO-1:0]  unit_next [0:7];
    logic signed [RPW-1:0] rp_reg [0:7];
    logic signed [RPW-1:0] rp_next [0:7];
    logic signed [RVW-1:0] rv_reg [0:7];
    logic signed [RVW-1:0] rv_next [0:7];
    logic signed [31:0]    pt_reg [0:7];
    logic signed [31:0]    pt_next [0:7];

    assign busy = 1'b0;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = S_IN; k <= S_G2; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[S_IN] <= start & ~busy;
            for (int k = S_IN + 1; k <= S_G2; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // angle set-up: sweep clamp, mid angle, quadrant count, reduction
    always_comb
    begin
        logic signed [31:0] swe;
        swe = 32'(sweep_reg);
        if (swe > 32'(SWEEP_MAX))
        begin
            sw1_next = 32'(SWEEP_MAX);
        end
        else if (swe < -32'(SWEEP_MAX))
        begin
            sw1_next = -32'(SWEEP_MAX);
        end
        else
        begin
            sw1_next = swe;
        end
        m1_next = (34'(start_reg) <<< 1) + 34'(sw1_next);
    end

    always_comb
    begin
        logic signed [34:0] mp;
        logic signed [34:0] thr;
        logic [3:0]         cnt;
        mp  = 35'(m1_reg) + 35'(ANG_PI4);
        cnt = '0;
        for (int k = -5; k <= 6; k++)
        begin
            thr = 35'(longint'(k) * ANG_PI2);
            cnt = cnt + 4'(mp >= thr);
        end
        q2_next = signed'(cnt - 4'd6);
    end

    always_comb
    begin
        logic signed [35:0] qp;
        qp      = 36'(longint'(q2_reg) * ANG_PI2);
        r3_next = 32'(36'(m2_reg) - qp);
    end

    always_ff @(posedge clk)
    begin
        geo_reg[S_IN] <= '{cx: center_x, cy: center_y, rx: radius_x, ry: radius_y};
        start_reg     <= arc_start;
        sweep_reg     <= arc_sweep;
        for (int k = S_IN + 1; k <= S_G1; k++)
        begin
            geo_reg[k] <= geo_reg[k-1];
        end

        sw1_reg        <= sw1_next;
        m1_reg         <= m1_next;
        zf_reg[S_ANG]  <= (sw1_next == '0);
        for (int k = S_ANG + 1; k <= S_CL; k++)
        begin
            zf_reg[k] <= zf_reg[k-1];
        end

        sw2_reg <= sw1_reg;
        m2_reg  <= m1_reg;
        q2_reg  <= q2_next;

        sw3_reg       <= sw2_reg;
        r3_reg        <= r3_next;
        qd_reg[S_RED] <= q2_reg[1:0];
        for (int k = S_RED + 1; k <= S_CL; k++)
        begin
            qd_reg[k] <= qd_reg[k-1];
        end
    end

    // two CORDIC pipelines: half sweep and reduced mid angle
    always_ff @(posedge clk)
    begin
        ch_reg[0] <= cord_step('{x: UW'(CORDIC_GAIN), y: '0, z: sw3_reg}, 0);
        cq_reg[0] <= cord_step('{x: UW'(CORDIC_GAIN), y: '0, z: r3_reg}, 0);
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            ch_reg[i] <= cord_step(ch_reg[i-1], i);
            cq_reg[i] <= cord_step(cq_reg[i-1], i);
        end
    end

    // quadrant fix-up, zero sweep, 4*(1-c)
    always_comb
    begin
        logic signed [UW-1:0] cr;
        logic signed [UW-1:0] sr;
        logic signed [UW-1:0] n;
        cr = cq_reg[CORDIC_STEPS-1].x;
        sr = cq_reg[CORDIC_STEPS-1].y;
        case (qd_reg[S_CL])
            2'd0:
            begin
                trig_next.cm = cr;
                trig_next.sm = sr;
            end
            2'd1:
            begin
                trig_next.cm = -sr;
                trig_next.sm = cr;
            end
            2'd2:
            begin
                trig_next.cm = -cr;
                trig_next.sm = -sr;
            end
            default:
            begin
                trig_next.cm = sr;
                trig_next.sm = -cr;
            end
        endcase
        if (zf_reg[S_CL])
        begin
            trig_next.c = UW'(ONE_Q30);
            trig_next.s = '0;
        end
        else
        begin
            trig_next.c = ch_reg[CORDIC_STEPS-1].x;
            trig_next.s = ch_reg[CORDIC_STEPS-1].y;
        end
        n         = (UW'(ONE_Q30) - trig_next.c) <<< 2;
        nneg_next = n[UW-1];
        nmag_next = 32'(nneg_next ? -n : n);
    end

    // tx from the reciprocal product, c + tx
    always_comb
    begin
        logic [30:0] tq;
        tq      = txp_reg[63:33];
        tx_next = txn_reg ? -signed'(UW'(tq)) : signed'(UW'(tq));
    end

    // divider set-up for tx*c / s
    always_comb
    begin
        logic signed [PW-1:0] tcm;
        logic signed [UW-1:0] s;
        logic signed [UW-1:0] sa;
        logic [NW-1:0]        nm;
        s   = trig_reg[S_T3].s;
        tcm = tc_reg[PW-1] ? -tc_reg : tc_reg;
        sa  = s[UW-1] ? -s : s;
        nm  = tcm[NW-1:0];
        dv0_next.nlo   = nm[QW-1:0];
        dv0_next.den   = sa[DW-1:0];
        dv0_next.rem   = DW'(nm[NW-1:QW]);
        dv0_next.quo   = '0;
        dv0_next.neg   = tc_reg[PW-1] ^ s[UW-1];
        dv0_next.ovf   = (DW'(nm[NW-1:QW]) >= sa[DW-1:0]);
        dv0_next.szero = (s == '0);
    end

    // one quotient bit per stage, most significant first
    always_comb
    begin
        logic [DW:0] trial;
        for (int j = 0; j < QW; j++)
        begin
            dv_next[S_D0+j] = dv_reg[S_D0+j-1];
            trial = {dv_reg[S_D0+j-1].rem, dv_reg[S_D0+j-1].nlo[QW-1-j]};
            if (trial >= {1'b0, dv_reg[S_D0+j-1].den})
            begin
                dv_next[S_D0+j].rem          = DW'(trial - {1'b0, dv_reg[S_D0+j-1].den});
                dv_next[S_D0+j].quo[QW-1-j]  = 1'b1;
            end
            else
            begin
                dv_next[S_D0+j].rem = trial[DW-1:0];
            end
        end
    end

    // clamp quotient, then ty
    always_comb
    begin
        logic [QW-1:0] qm;
        if (dv_reg[S_DL].ovf || dv_reg[S_DL].quo > QW'(TY_LIM))
        begin
            qm = QW'(TY_LIM);
        end
        else
        begin
            qm = dv_reg[S_DL].quo;
        end
        qt_next = dv_reg[S_DL].neg ? -signed'(34'(qm)) : signed'(34'(qm));
    end

    always_comb
    begin
        logic signed [34:0] d;
        d = 35'(trig_reg[S_E0].s) - 35'(qt_reg);
        if (ez_reg)
        begin
            ty_next = '0;
        end
        else if (d > 35'(TY_LIM))
        begin
            ty_next = UW'(TY_LIM);
        end
        else if (d < -35'(TY_LIM))
        begin
            ty_next = -UW'(TY_LIM);
        end
        else
        begin
            ty_next = UW'(d);
        end
    end

    always_ff @(posedge clk)
    begin
        trig_reg[S_T0] <= trig_next;
        for (int k = S_T0 + 1; k <= S_E1; k++)
        begin
            trig_reg[k] <= trig_reg[k-1];
        end
        nmag_reg <= nmag_next;
        nneg_reg <= nneg_next;

        txp_reg <= 64'(nmag_reg) * 64'(RECIP3);
        txn_reg <= nneg_reg;

        tx_reg         <= tx_next;
        ct_reg[S_T2]   <= trig_reg[S_T1].c + tx_next;
        for (int k = S_T2 + 1; k <= S_E1; k++)
        begin
            ct_reg[k] <= ct_reg[k-1];
        end

        tc_reg <= tx_reg * trig_reg[S_T2].c;

        dv_reg[S_T4] <= dv0_next;
        for (int k = S_D0; k <= S_DL; k++)
        begin
            dv_reg[k] <= dv_next[k];
        end

        qt_reg <= qt_next;
        ez_reg <= dv_reg[S_DL].szero;
        ty_reg <= ty_next;
    end

    // rotation by the mid angle, then radius scaling and centre offset
    always_comb
    begin
        logic signed [UW-1:0] c;
        logic signed [UW-1:0] s;
        logic signed [UW-1:0] ct;
        logic signed [UW-1:0] cm;
        logic signed [UW-1:0] sm;
        c  = trig_reg[S_E1].c;
        s  = trig_reg[S_E1].s;
        cm = trig_reg[S_E1].cm;
        sm = trig_reg[S_E1].sm;
        ct = ct_reg[S_E1];
        prod_next[0] = c * cm;
        prod_next[1] = c * sm;
        prod_next[2] = ct * cm;
        prod_next[3] = ct * sm;
        prod_next[4] = s * sm;
        prod_next[5] = s * cm;
        prod_next[6] = ty_reg * sm;
        prod_next[7] = ty_reg * cm;
    end

    always_comb
    begin
        logic signed [PW:0] acc [0:7];
        acc[0] = 69'(prod_reg[0]) + 69'(prod_reg[4]);
        acc[1] = 69'(prod_reg[1]) - 69'(prod_reg[5]);
        acc[2] = 69'(prod_reg[2]) + 69'(prod_reg[6]);
        acc[3] = 69'(prod_reg[3]) - 69'(prod_reg[7]);
        acc[4] = 69'(prod_reg[2]) - 69'(prod_reg[6]);
        acc[5] = 69'(prod_reg[3]) + 69'(prod_reg[7]);
        acc[6] = 69'(prod_reg[0]) - 69'(prod_reg[4]);
        acc[7] = 69'(prod_reg[1]) + 69'(prod_reg[5]);
        for (int k = 0; k < 8; k++)
        begin
            unit_next[k] = UO'((acc[k] + 69'(RND30)) >>> 30);
        end
    end

    always_comb
    begin
        logic signed [31:0] rs;
        for (int k = 0; k < 8; k++)
        begin
            rs = (k % 2 == 0) ? signed'({1'b0, geo_reg[S_F1].rx})
                              : signed'({1'b0, geo_reg[S_F1].ry});
            rp_next[k] = rs * unit_reg[k];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            rv_next[k] = RVW'((rp_reg[k] + RPW'(RND30)) >>> 30);
        end
    end

    always_comb
    begin
        logic signed [RVW:0] v;
        for (int k = 0; k < 8; k++)
        begin
            v = (k % 2 == 0) ? 39'(rv_reg[k]) + 39'(geo_reg[S_G1].cx)
                             : 39'(rv_reg[k]) + 39'(geo_reg[S_G1].cy);
            if (v > 39'(32'sh7FFF_FFFF))
            begin
                pt_next[k] = 32'sh7FFF_FFFF;
            end
            else if (v < 39'(-TY_LIM))
            begin
                pt_next[k] = 32'sh8000_0000;
            end
            else
            begin
                pt_next[k] = 32'(v);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 8; k++)
        begin
            prod_reg[k] <= prod_next[k];
            unit_reg[k] <= unit_next[k];
            rp_reg[k]   <= rp_next[k];
            rv_reg[k]   <= rv_next[k];
            pt_reg[k]   <= pt_next[k];
        end
    end

    assign done = vld_reg[S_G2];
    assign p0_x = pt_reg[0];
    assign p0_y = pt_reg[1];
    assign p1_x = pt_reg[2];
    assign p1_y = pt_reg[3];
    assign p2_x = pt_reg[4];
    assign p2_y = pt_reg[5];
    assign p3_x = pt_reg[6];
    assign p3_y = pt_reg[7];

endmodule

[tb/tb_arc_segment_to_cubic_bezier_top.sv]
// Testbench for arc_segment_to_cubic_bezier_top: a directed table, then random
// arc segments; each result is checked against a fixed-point predictor or a typed value.
// Depends on arcbz_pkg and the block under test; reads no files.
`timescale 1ns / 100ps

module tb_arc_segment_to_cubic_bezier_top;
    import arcbz_pkg::*;

    typedef struct {
        longint cx;
        longint cy;
        longint rx;
        longint ry;
        longint sa;
        longint sw;
    } seg_t;

    typedef struct {
        logic signed [31:0] x[4];
        logic signed [31:0] y[4];
    } ctrl_pts_t;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        rx;
        logic [30:0]        ry;
        logic signed [31:0] sa;
        logic signed [29:0] sw;
        bit                 typed;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } row_t;

    localparam longint ATAN_Q29[30] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
        8, 4, 2, 1};
    localparam int LIMIT = 200000;
    localparam int DRAIN = 120;
    localparam int N_RAND = 450;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius_x;
    logic [30:0]        radius_y;
    logic signed [31:0] arc_start;
    logic signed [29:0] arc_sweep;
    logic               done;
    logic signed [31:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;

    logic      busy_q;
    ctrl_pts_t pending_pts[$];
    int        errors = 0;
    int        n_sent;
    int        n_checked = 0;
    int        n_typed;
    int        cycles = 0;

    arc_segment_to_cubic_bezier_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .center_x(center_x), .center_y(center_y),
        .radius_x(radius_x), .radius_y(radius_y),
        .arc_start(arc_start), .arc_sweep(arc_sweep),
        .done(done),
        .p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
        .p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // busy as seen through the cycle that ends at the next rising edge
    always @(negedge clk) busy_q <= busy;

    function automatic longint lclamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void unit_cordic(longint z, output longint c, output longint s);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_Q29[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_Q29[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic void rotation_trig(longint a, output longint c, output longint s);
        int     quad;
        longint cr;
        longint sr;
        quad = 0;
        while (a > ANG_PI4)
        begin
            a -= ANG_PI2; quad++;
        end
        while (a < -ANG_PI4)
        begin
            a += ANG_PI2; quad--;
        end
        unit_cordic(a, cr, sr);
        case (quad & 3)
            0: begin c = cr;  s = sr;  end
            1: begin c = -sr; s = cr;  end
            2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
        endcase
    endfunction

    function automatic logic signed [31:0] scale_offset(longint ctr, longint rad, longint u);
        longint v;
        v = ((rad * u + RND30) >>> 30) + ctr;
        return 32'(lclamp(v, -64'sd2147483648, 64'sd2147483647));
    endfunction

    function automatic ctrl_pts_t bezier_pts(seg_t g);
        ctrl_pts_t r;
        longint sw, c, s, tx, ty, qt, cm, sm, ux, uy;
        longint px[4];
        longint py[4];
        sw = lclamp(g.sw, -SWEEP_MAX, SWEEP_MAX);
        if (sw == 0)
        begin
            c = ONE_Q30; s = 0; tx = 0; ty = 0;
        end
        else
        begin
            unit_cordic(sw, c, s);
            tx = ((ONE_Q30 - c) * 4) / 3;
            if (s == 0)
                ty = 0;
            else
            begin
                qt = lclamp((tx * c) / s, -TY_LIM, TY_LIM);
                ty = lclamp(s - qt, -TY_LIM, TY_LIM);
            end
        end
        px[0] = c;      py[0] = -s;
        px[1] = c + tx; py[1] = -ty;
        px[2] = c + tx; py[2] = ty;
        px[3] = c;      py[3] = s;
        rotation_trig(2 * g.sa + sw, cm, sm);
        for (int i = 0; i < 4; i++)
        begin
            ux = (px[i] * cm - py[i] * sm + RND30) >>> 30;
            uy = (px[i] * sm + py[i] * cm + RND30) >>> 30;
            r.x[i] = scale_offset(g.cx, g.rx, ux);
            r.y[i] = scale_offset(g.cy, g.ry, uy);
        end
        return r;
    endfunction

    task automatic send_segment(row_t rw);
        int        gap;
        seg_t      g;
        ctrl_pts_t e;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        center_x    <= rw.cx;
        center_y    <= rw.cy;
        radius_x    <= rw.rx;
        radius_y    <= rw.ry;
        arc_start   <= rw.sa;
        arc_sweep   <= rw.sw;
        do @(posedge clk); while (busy_q);
        g.cx = rw.cx; g.cy = rw.cy; g.rx = rw.rx; g.ry = rw.ry;
        g.sa = rw.sa; g.sw = rw.sw;
        if (rw.typed)
        begin
            for (int i = 0; i < 4; i++)
            begin
                e.x[i] = rw.ex;
                e.y[i] = rw.ey;
            end
            n_typed++;
        end
        else
            e = bezier_pts(g);
        pending_pts.push_back(e);
        n_sent++;
    endtask

    function automatic row_t mk(longint cx, longint cy, longint rx, longint ry,
                                longint sa, longint sw);
        row_t r;
        r.cx = cx; r.cy = cy; r.rx = rx; r.ry = ry; r.sa = sa; r.sw = sw;
        r.typed = 1'b0; r.ex = 0; r.ey = 0;
        return r;
    endfunction

    function automatic row_t mk_pt(longint cx, longint cy, longint sa, longint sw);
        row_t r;
        r = mk(cx, cy, 0, 0, sa, sw);
        r.typed = 1'b1; r.ex = cx; r.ey = cy;
        return r;
    endfunction

    function automatic row_t rand_segment();
        row_t r;
        r = mk($signed($urandom()), $signed($urandom()), $urandom() & 32'h7fffffff,
               $urandom() & 32'h7fffffff, $signed($urandom()), 0);
        if ($urandom_range(0, 2) == 0)
        begin
            r.cx = $signed(32'($urandom_range(0, 32'h01ffffff))) - 32'sh01000000;
            r.cy = $signed(32'($urandom_range(0, 32'h01ffffff))) - 32'sh01000000;
            r.rx = $urandom_range(0, 32'h00ffffff);
            r.ry = $urandom_range(0, 32'h00ffffff);
        end
        case ($urandom_range(0, 9))
            0: r.sw = 0;
            1, 2: r.sw = $signed(30'($urandom()));
            3: r.sw = $signed(30'($urandom_range(0, 63))) - 32;
            default: r.sw = longint'($urandom_range(0, 2 * 421657428)) - 421657428;
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_pts.size() == 0)
            begin
                $error("result transfer with nothing pending");
                errors++;
            end
            else
            begin
                ctrl_pts_t e;
                logic signed [31:0] ax[4];
                logic signed [31:0] ay[4];
                e = pending_pts.pop_front();
                ax = '{p0_x, p1_x, p2_x, p3_x};
                ay = '{p0_y, p1_y, p2_y, p3_y};
                for (int i = 0; i < 4; i++)
                begin
                    if (ax[i] !== e.x[i])
                    begin
                        $error("p%0d_x expected %0d actual %0d", i, e.x[i], ax[i]);
                        errors++;
                    end
                    if (ay[i] !== e.y[i])
                    begin
                        $error("p%0d_y expected %0d actual %0d", i, e.y[i], ay[i]);
                        errors++;
                    end
                end
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        row_t dir_rows[$];
        n_sent = 0; n_typed = 0;
        rst_n = 1'b0;
        start = 1'b0;
        center_x = '0; center_y = '0; radius_x = '0; radius_y = '0;
        arc_start = '0; arc_sweep = '0;
        // zero radii collapse every point onto the centre
        dir_rows.push_back(mk_pt(0, 0, 0, 0));
        dir_rows.push_back(mk_pt(2147483647, -2147483648, 0, 421657428));
        dir_rows.push_back(mk_pt(-2147483648, 2147483647, -2147483648, -421657428));
        dir_rows.push_back(mk_pt(12345, -6789, 2147483647, 536870911));
        // unit and extreme radii, full and saturated sweeps
        dir_rows.push_back(mk(0, 0, 65536, 65536, 0, 0));
        dir_rows.push_back(mk(0, 0, 65536, 65536, 0, 421657428));
        dir_rows.push_back(mk(0, 0, 65536, 65536, 0, -421657428));
        dir_rows.push_back(mk(0, 0, 65536, 65536, 0, 536870911));
        dir_rows.push_back(mk(0, 0, 65536, 65536, 0, -536870912));
        dir_rows.push_back(mk(0, 0, 65536, 65536, 0, 1));
        dir_rows.push_back(mk(0, 0, 65536, 65536, 0, -1));
        dir_rows.push_back(mk(0, 0, 2147483647, 2147483647, 0, 421657428));
        dir_rows.push_back(mk(2147483647, 2147483647, 2147483647, 2147483647, 0, 421657428));
        dir_rows.push_back(mk(-2147483648, -2147483648, 2147483647, 2147483647,
                              843314857, -421657428));
        // large start angles in every quadrant
        dir_rows.push_back(mk(100, 200, 65536, 131072, 2147483647, 100000000));
        dir_rows.push_back(mk(100, 200, 65536, 131072, -2147483648, -100000000));
        dir_rows.push_back(mk(0, 0, 65536, 65536, 421657428, 0));
        dir_rows.push_back(mk(0, 0, 65536, 65536, 843314857, 0));
        dir_rows.push_back(mk(0, 0, 65536, 65536, -843314857, 300000000));
        dir_rows.push_back(mk(0, 0, 2147483647, 0, 210828714, 2));
        dir_rows.push_back(mk(0, 0, 0, 2147483647, -210828714, -2));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_segment(dir_rows[i]);
        for (int k = 0; k < N_RAND; k++)
            send_segment(rand_segment());
        start <= 1'b0;
        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        $display("%0d arc segments sent (%0d with typed results), %0d results checked",
                 n_sent, n_typed, n_checked);
        $display("covered zero and saturated sweeps, extreme radii, centres and start angles");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
